// File: sv/sensitive_line_matcher_defines.svh
// ----------------------------------------------------------------------------
// Sensitive line matcher assertion macros
// Shared assertion forms for the checker attached to the matcher.
// ----------------------------------------------------------------------------
`ifndef SENSITIVE_LINE_MATCHER_DEFINES_SVH
`define SENSITIVE_LINE_MATCHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/slm_pkg.sv
// ----------------------------------------------------------------------------
// Sensitive line matcher package
// Keyword table, history type and the byte folding and keyword compare
// functions used by the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package slm_pkg;

   localparam int HISTORY_BYTES = 12;
   localparam int KEY_COUNT     = 9;
   localparam int KEY_MAX       = 13;
   localparam int KEY_LEN_W     = 4;

   typedef logic [HISTORY_BYTES-1:0][7:0] hist_type;

   // Each keyword is right-aligned: byte 0 holds its last character.
   localparam logic [KEY_MAX*8-1:0] KEY_TEXT [KEY_COUNT] = '{
      {40'd0, "password"},
      {56'd0, "passwd"},
      {56'd0, "secret"},
      "authorization",
      {48'd0, "bearer "},
      {16'd0, "private key"},
      {16'd0, "private", "_key"},
      {8'd0,  "access", "_token"},
      {48'd0, "api_key"}
   };

   localparam logic [KEY_LEN_W-1:0] KEY_LEN [KEY_COUNT] = '{
      4'd8, 4'd6, 4'd6, 4'd13, 4'd7, 4'd11, 4'd11, 4'd12, 4'd7
   };

   function automatic logic [7:0] fold_byte(input logic [7:0] raw);
      logic [7:0] folded;
      folded = raw;
      if (raw inside {[8'h41:8'h5A]}) begin
         folded = raw + 8'h20;
      end
      return folded;
   endfunction

   // True when any keyword ends at the current folded byte.
   function automatic logic key_hit(input logic [7:0] cur, input hist_type hist);
      logic hit;
      logic match;
      hit = 1'b0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         match = (KEY_TEXT[i][7:0] == cur);
         for (int k = 1; k < KEY_MAX; k++) begin
            if (k < int'(KEY_LEN[i]) && k <= HISTORY_BYTES) begin
               if (KEY_TEXT[i][8*k +: 8] != hist[k-1]) begin
                  match = 1'b0;
               end
            end
         end
         hit = hit | match;
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

// File: sv/sensitive_line_matcher.sv
// ----------------------------------------------------------------------------
// Sensitive line matcher
// One byte transaction is accepted per cycle while the input does not stall.
// A line's final byte is held in the input register; when it advances, the
// result valid and the verdict are registered. The input stalls only while a
// line's final byte waits behind a held result. Synchronous reset clears
// the history and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sensitive_line_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_line_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_sensitive
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_eol_ff;
   slm_pkg::hist_type hist_ff;
   slm_pkg::hist_type hist_in;
   logic              hit_seen_ff;
   logic              hit_seen_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_sensitive_ff;

   logic [7:0]        folded;
   logic              hit;
   logic              advance;
   logic              req_take;
   logic              rsp_take;

   always_comb begin
      folded    = slm_pkg::fold_byte(in_byte_ff);
      hit       = hit_seen_ff | slm_pkg::key_hit(folded, hist_ff);
      advance   = in_valid_ff && (!in_eol_ff || !rsp_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !advance;
      req_take  = req_valid && !req_stall;
      rsp_take  = rsp_valid_ff && !rsp_stall;
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      hist_in      = hist_ff;
      hit_seen_in  = hit_seen_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         if (in_eol_ff) begin
            hist_in      = '0;
            hit_seen_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            hist_in     = {hist_ff[slm_pkg::HISTORY_BYTES-2:0], folded};
            hit_seen_in = hit;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         hist_ff      <= '0;
         hit_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         hist_ff      <= hist_in;
         hit_seen_ff  <= hit_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_line_byte;
         in_eol_ff  <= req_end_of_line;
      end
      if (advance && in_eol_ff) begin
         rsp_sensitive_ff <= hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sensitive = rsp_sensitive_ff;

endmodule

`default_nettype wire

// File: sv/slm_checker.sv
// ----------------------------------------------------------------------------
// Sensitive line matcher checker
// Port-level checks on the matcher's handshakes and rate, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensitive_line_matcher_defines.svh"

module slm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       req_end_of_line,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_sensitive
);

   logic req_take;
   logic req_line_end;

   assign req_take     = req_valid && !req_stall;
   assign req_line_end = req_take && req_end_of_line;

   // A stalled result transaction keeps its payload.
   `SLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sensitive), "stalled result transaction changed")

   // With the result side free, the input side never stalls.
   `SLM_ASSERT_SAME(a_no_stall_when_free, clock, reset, !rsp_stall, !req_stall, "input stalled while result side was free")

   // A byte that does not end a line never blocks the next one.
   `SLM_ASSERT_NEXT(a_back_to_back, clock, reset, req_take && !req_end_of_line, !req_stall, "input stalled after a mid-line byte")

   // A line end that then finds the result side free sets the registered result valid.
   `SLM_ASSERT_NEXT(a_line_result, clock, reset, $past(req_line_end) && !rsp_stall, rsp_valid, "line end gave no result transaction")

   // No result is offered straight after reset.
   `SLM_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "result transaction offered after reset")

endmodule

bind sensitive_line_matcher slm_checker u_slm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_end_of_line (req_end_of_line),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_sensitive   (rsp_sensitive)
);

`default_nettype wire

// File: tb/sensitive_line_matcher_checker.sv
// ----------------------------------------------------------------------------
// Sensitive line matcher checker
// Watches both channels of the matcher. It scans every accepted byte
// transaction and predicts whether each line is sensitive. It compares every
// accepted result transaction with the oldest prediction still waiting and
// counts the failures.
// ----------------------------------------------------------------------------
module sensitive_line_matcher_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_line_byte,
   input  logic       req_end_of_line,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_sensitive,
   output int         error_count,
   output int         verdicts_pending
);

   localparam int HISTORY_DEPTH = 12;
   localparam int KEYWORD_TOTAL = 9;

   string keywords [KEYWORD_TOTAL] = '{
      "password", "passwd", "secret", "authorization", "bearer ",
      "private key", "private\137key", "access\137token", "api_key"
   };

   logic [7:0] history [HISTORY_DEPTH];
   logic       hit_latched;
   logic       verdicts_due [$];
   int         errors_seen = 0;

   initial begin
      error_count      = 0;
      verdicts_pending = 0;
   end

   function automatic logic [7:0] lower_case(input logic [7:0] raw);
      if (raw >= 8'h41 && raw <= 8'h5A) begin
         return raw + 8'h20;
      end
      return raw;
   endfunction

   function automatic logic keyword_ends(input string kw, input logic [7:0] cur);
      int   len;
      logic found;
      len   = kw.len();
      found = (kw[len-1] == cur);
      for (int k = 1; k < len; k++) begin
         if (k > HISTORY_DEPTH || kw[len-1-k] != history[k-1]) begin
            found = 1'b0;
         end
      end
      return found;
   endfunction

   task automatic clear_line();
      foreach (history[i]) begin
         history[i] = 8'h00;
      end
      hit_latched = 1'b0;
   endtask

   // Advances the line state by one byte; the final byte yields a verdict.
   task automatic scan_byte(input logic [7:0] raw, input logic last);
      logic [7:0] cur;
      logic       hit;
      cur = lower_case(raw);
      hit = hit_latched;
      foreach (keywords[i]) begin
         if (keyword_ends(keywords[i], cur)) begin
            hit = 1'b1;
         end
      end
      if (last) begin
         verdicts_due.push_back(hit);
         clear_line();
      end else begin
         for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            history[i] = history[i-1];
         end
         history[0]  = cur;
         hit_latched = hit;
      end
   endtask

   always @(posedge clock) begin
      logic expected;
      if (reset) begin
         clear_line();
         verdicts_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $error("sensitive: no transaction expected, actual %0b", rsp_sensitive);
               errors_seen++;
            end else begin
               expected = verdicts_due.pop_front();
               if (rsp_sensitive !== expected) begin
                  $error("sensitive: expected %0b, actual %0b", expected, rsp_sensitive);
                  errors_seen++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            scan_byte(req_line_byte, req_end_of_line);
         end
      end
      error_count      <= errors_seen;
      verdicts_pending <= verdicts_due.size();
   end

endmodule

// File: tb/sensitive_line_matcher_tb.sv
// ----------------------------------------------------------------------------
// Sensitive line matcher testbench
// Sends directed lines and then random log lines, most of them carrying a
// keyword in mixed case, whole, damaged or cut short, under changing idle
// and stall patterns, including a long result hold-off that fills the block.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sensitive_line_matcher_tb;

   typedef enum logic [1:0] {PH_RX_SLOW, PH_TX_SLOW, PH_BACKLOG, PH_STEADY} phase_type;

   localparam int LINE_BYTES_TARGET = 1550;
   localparam int BACKLOG_HOLD      = 300;
   localparam int BACKLOG_LINES     = 40;

   string keywords [9] = '{
      "password", "passwd", "secret", "authorization", "bearer ",
      "private key", "private\137key", "access\137token", "api_key"
   };
   string letter_pool = "aeiknoprstyz_ ";

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_line_byte   = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic       rsp_sensitive;
   int         error_count;
   int         verdicts_pending;

   phase_type  phase      = PH_RX_SLOW;
   int         bytes_sent = 0;
   logic [7:0] line_buf [$];

   sensitive_line_matcher uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_line_byte   (req_line_byte),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sensitive   (rsp_sensitive)
   );

   sensitive_line_matcher_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_line_byte    (req_line_byte),
      .req_end_of_line  (req_end_of_line),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sensitive    (rsp_sensitive),
      .error_count      (error_count),
      .verdicts_pending (verdicts_pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // The receiver stalls at random only in the two slow phases, apart from one
   // long hold-off that fills the block while the sender keeps offering transactions.
   initial begin : rx_side
      int hold_left;
      bit backlog_started;
      hold_left       = 0;
      backlog_started = 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_BACKLOG && !backlog_started) begin
            backlog_started = 1'b1;
            hold_left       = BACKLOG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (phase)
               PH_RX_SLOW: begin
                  rsp_stall <= ($urandom_range(99) < 63);
               end
               PH_TX_SLOW: begin
                  rsp_stall <= ($urandom_range(99) < 7);
               end
               default: begin
                  rsp_stall <= 1'b0;
               end
            endcase
         end
      end
   end

   function automatic logic [7:0] mixed_case(input logic [7:0] raw);
      if (raw >= "a" && raw <= "z" && $urandom_range(1) == 1) begin
         return raw - 8'h20;
      end
      return raw;
   endfunction

   function automatic logic [7:0] filler_byte();
      if ($urandom_range(1) == 1) begin
         return 8'($urandom_range(255));
      end
      return mixed_case(letter_pool[$urandom_range(letter_pool.len() - 1)]);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int idle_pct;
      case (phase)
         PH_RX_SLOW: idle_pct = 7;
         PH_TX_SLOW: idle_pct = 63;
         default:    idle_pct = 0;
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_line_byte   <= value;
      req_end_of_line <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_buffered_line();
      foreach (line_buf[i]) begin
         send_byte(line_buf[i], i == line_buf.size() - 1);
      end
   endtask

   task automatic send_text(input string text);
      line_buf.delete();
      for (int i = 0; i < text.len(); i++) begin
         line_buf.push_back(text[i]);
      end
      send_buffered_line();
   endtask

   task automatic build_line();
      int    kind;
      int    cut;
      int    spoil;
      string kw;
      line_buf.delete();
      repeat ($urandom_range(8)) line_buf.push_back(filler_byte());
      kind  = $urandom_range(99);
      kw    = keywords[$urandom_range(8)];
      cut   = kw.len();
      spoil = -1;
      if (kind >= 60 && kind < 75) begin
         spoil = $urandom_range(kw.len() - 1);
      end else if (kind >= 75 && kind < 85) begin
         cut = $urandom_range(kw.len() - 1, 1);
      end
      if (kind < 85) begin
         for (int i = 0; i < cut; i++) begin
            if (i == spoil) begin
               line_buf.push_back(8'($urandom_range(255)));
            end else begin
               line_buf.push_back(mixed_case(kw[i]));
            end
         end
      end
      if (!(kind >= 75 && kind < 85 && $urandom_range(1) == 1)) begin
         repeat ($urandom_range(8)) line_buf.push_back(filler_byte());
      end
      if (line_buf.size() == 0) begin
         line_buf.push_back(filler_byte());
      end
   endtask

   task automatic send_random_lines(input int byte_goal);
      while (bytes_sent < byte_goal) begin
         build_line();
         send_buffered_line();
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_text("PassWD");
      send_text("secre");
      send_text("t");
      send_text("AUTHORIZATION");

      send_random_lines(LINE_BYTES_TARGET / 3);
      drain();

      phase = PH_TX_SLOW;
      send_random_lines(2 * LINE_BYTES_TARGET / 3);
      drain();

      phase = PH_BACKLOG;
      repeat (BACKLOG_LINES) send_byte(filler_byte(), 1'b1);
      drain();

      phase = PH_STEADY;
      send_random_lines(LINE_BYTES_TARGET);
      drain();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/slm_pkg.sv
sv/sensitive_line_matcher.sv
sv/slm_checker.sv
tb/sensitive_line_matcher_checker.sv
tb/sensitive_line_matcher_tb.sv
